### rtl/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cell writer: request and
// response payloads, controller commands and datapath status.
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam logic       KIND_PUT     = 1'b0;
   localparam logic       KIND_READ    = 1'b1;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_RETURN  = 8'd13;
   localparam logic [7:0] ATTR_RESET   = 8'h07;
   localparam logic [7:0] CHAR_BLANK   = 8'h00;

   typedef struct packed {
      logic        kind;
      logic [7:0]  char_code;
      logic [10:0] read_address;
   } tccw_req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [15:0] cell_data;
   } tccw_rsp_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_EXEC,
      OP_SCROLL_RD,
      OP_SCROLL_WR,
      OP_BLANK,
      OP_RESPOND
   } tccw_op_type;

   typedef struct packed {
      tccw_op_type op;
   } tccw_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic copy_last;
      logic wrap;
      logic out_busy;
   } tccw_status_type;

endpackage
`default_nettype wire

### rtl/tccw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for the cell writer: clearing pass after reset, request load,
// execute, scroll copy, last row blanking and response hand-off.
// ----------------------------------------------------------------------------
module tccw_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  tccw_pkg::tccw_status_type status,
   output tccw_pkg::tccw_cmd_type    cmd
);
   import tccw_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_BLANK,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.op   = OP_EXEC;
            state_in = status.wrap ? ST_SCROLL_RD : ST_RESP;
         end
         ST_SCROLL_RD: begin
            cmd.op   = OP_SCROLL_RD;
            state_in = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            cmd.op   = OP_SCROLL_WR;
            state_in = status.copy_last ? ST_BLANK : ST_SCROLL_RD;
         end
         ST_BLANK: begin
            cmd.op = OP_BLANK;
            if (status.scan_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!status.out_busy) begin
               cmd.op   = OP_RESPOND;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // an accepted request always goes to execute next
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not reach execute");

endmodule
`default_nettype wire

### rtl/tccw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_datapath
// Cell memory, cursor registers, attribute register, scan counter and
// response register of the cell writer.
// ----------------------------------------------------------------------------
module tccw_datapath #(
   parameter int ROWS    = 25,
   parameter int COLUMNS = 80
) (
   input  wire                       clock,
   input  wire                       reset,
   input  tccw_pkg::tccw_cmd_type    cmd,
   output tccw_pkg::tccw_status_type status,
   input  tccw_pkg::tccw_req_type    req_payload,
   input  wire                       csr_valid,
   input  wire  [7:0]                csr_data,
   input  wire                       rsp_ready,
   output logic                      rsp_valid,
   output tccw_pkg::tccw_rsp_type    rsp_payload
);
   import tccw_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int RW         = $clog2(ROWS);
   localparam int CW         = $clog2(COLUMNS);
   localparam logic [AW+10:0] CELL_LIMIT = (AW + 11)'(CELL_COUNT);
   localparam logic [AW-1:0]  LAST_CELL  = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0]  COPY_LAST  = AW'(CELL_COUNT - COLUMNS - 1);
   localparam logic [AW-1:0]  LAST_ROW0  = AW'(CELL_COUNT - COLUMNS);
   localparam logic [AW-1:0]  COL_STEP   = AW'(COLUMNS);
   localparam logic [RW-1:0]  ROW_MAX    = RW'(ROWS - 1);
   localparam logic [CW-1:0]  COL_MAX    = CW'(COLUMNS - 1);

   logic [15:0]   cells_ff [CELL_COUNT];
   logic [15:0]   rdata_ff;
   tccw_req_type  req_ff;
   logic [7:0]    attr_ff;
   logic [AW-1:0] scan_ff;
   logic [AW-1:0] scan_in;
   logic [AW-1:0] lin_ff;
   logic [AW-1:0] lin_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic          rsp_valid_ff;
   tccw_rsp_type  rsp_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;

   logic          is_put;
   logic          is_newline;
   logic          is_return;
   logic          is_print;
   logic          on_last_row;
   logic [AW+10:0] raddr_wide;
   logic          read_hit;
   logic [AW-1:0] row_start;

   assign is_put      = (req_ff.kind == KIND_PUT);
   assign is_newline  = is_put && (req_ff.char_code == CODE_NEWLINE);
   assign is_return   = is_put && (req_ff.char_code == CODE_RETURN);
   assign is_print    = is_put && !is_newline && !is_return;
   assign on_last_row = (row_ff == ROW_MAX);
   assign raddr_wide  = {{AW{1'b0}}, req_ff.read_address};
   assign read_hit    = (req_ff.kind == KIND_READ) && (raddr_wide < CELL_LIMIT);
   assign row_start   = lin_ff - AW'(col_ff);

   assign status.scan_last = (scan_ff == LAST_CELL);
   assign status.copy_last = (scan_ff == COPY_LAST);
   assign status.wrap      = on_last_row
                             && (is_newline || (is_print && (col_ff == COL_MAX)));
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = scan_ff;
      mem_wdata = {ATTR_RESET, CHAR_BLANK};
      mem_re    = 1'b0;
      mem_raddr = raddr_wide[AW-1:0];
      scan_in   = scan_ff;
      lin_in    = lin_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      unique case (cmd.op)
         OP_CLEAR: begin
            mem_we  = 1'b1;
            scan_in = status.scan_last ? '0 : scan_ff + 1'b1;
         end
         OP_EXEC: begin
            if (read_hit) begin
               mem_re = 1'b1;
            end
            if (is_print) begin
               mem_we    = 1'b1;
               mem_waddr = lin_ff;
               mem_wdata = {attr_ff, req_ff.char_code};
            end
            if (status.wrap) begin
               lin_in = LAST_ROW0;
               row_in = ROW_MAX;
               col_in = '0;
            end else if (is_newline) begin
               lin_in = row_start + COL_STEP;
               row_in = row_ff + 1'b1;
               col_in = '0;
            end else if (is_return) begin
               lin_in = row_start;
               col_in = '0;
            end else if (is_print) begin
               lin_in = lin_ff + 1'b1;
               if (col_ff == COL_MAX) begin
                  row_in = row_ff + 1'b1;
                  col_in = '0;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         OP_SCROLL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = scan_ff + COL_STEP;
         end
         OP_SCROLL_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
            scan_in   = scan_ff + 1'b1;
         end
         OP_BLANK: begin
            mem_we    = 1'b1;
            mem_wdata = {attr_ff, CHAR_BLANK};
            scan_in   = status.scan_last ? '0 : scan_ff + 1'b1;
         end
         OP_IDLE, OP_LOAD, OP_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= cells_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         req_ff <= req_payload;
      end
      if (cmd.op == OP_RESPOND) begin
         rsp_ff.cursor_position <= 11'(lin_ff);
         rsp_ff.cell_data       <= read_hit ? rdata_ff : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         scan_ff      <= '0;
         lin_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            attr_ff <= csr_data;
         end
         scan_ff <= scan_in;
         lin_ff  <= lin_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         if (cmd.op == OP_RESPOND) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // linear cursor agrees with row and column
   assert property (@(posedge clock) disable iff (reset)
      32'(lin_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff))
      else $error("cursor index out of step with row and column");

   // cursor stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      (32'(lin_ff) < CELL_COUNT) && (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS))
      else $error("cursor off screen");

   // a response appears only after a respond command
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == OP_RESPOND))
      else $error("response without respond command");

endmodule
`default_nettype wire

### rtl/text_console_cell_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console of ROWS by COLUMNS 16-bit cells with a linear cursor, put and
// read requests, and one attribute register.
// ----------------------------------------------------------------------------
// After reset the cell memory is cleared to attribute 7, character 0 by a
// pass over all ROWS*COLUMNS cells during which req_ready stays low;
// attribute writes are taken at any time. A read or a put that does not
// scroll passes through load, execute and respond before the next acceptance.
// A newline on the last row, or a character put in its last column, scrolls
// the screen: each cell below the top row is read and written one row up,
// then the last row is blanked with the current attribute. The response
// sits in an output register, so a new request is accepted while it waits.
module text_console_cell_writer #(
   parameter int ROWS    = 25,
   parameter int COLUMNS = 80
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  tccw_pkg::tccw_req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output tccw_pkg::tccw_rsp_type rsp_payload,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [7:0]             csr_data
);
   import tccw_pkg::*;

   tccw_cmd_type    cmd;
   tccw_status_type status;

   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccw_datapath #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

### verif/text_console_cell_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_test
// Self-checking bench for the text console cell writer. A queue of put and
// read requests feeds a clocked driver; a clocked monitor compares every
// response against a cycle-free model of the cell store, cursor and scroll.
// Runs a directed opening at the reset attribute, then random text lines under
// several attribute settings, with random gaps on both sides, one phase
// without gaps and one long response hold-off.
// ----------------------------------------------------------------------------
module text_console_cell_writer_test;

   import tccw_pkg::*;

   localparam int ROWS       = 25;
   localparam int COLUMNS    = 80;
   localparam int CELLS      = ROWS * COLUMNS;
   localparam int LINE_ITEMS = 64;
   localparam int HOLD_AFTER = 60;
   localparam int LONG_HOLD  = 400;
   localparam int TAIL       = 20;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   tccw_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   tccw_rsp_type rsp_payload;
   logic         csr_valid   = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data    = 8'h00;

   // console model
   logic [15:0]  screen_model [CELLS];
   int unsigned  cursor_model;
   logic [7:0]   attribute_model;

   tccw_req_type outgoing_requests [$];
   tccw_rsp_type predicted_responses [$];
   int unsigned  queued_total;
   int unsigned  requests_taken;
   int unsigned  mismatch_count;
   bit           no_idle;
   int           send_gap;
   int           stall_left;
   int           hold_left;
   bit           hold_done;

   text_console_cell_writer #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic tccw_rsp_type advance_console(tccw_req_type r);
      tccw_rsp_type o;
      o = '0;
      if (r.kind == KIND_PUT) begin
         if (r.char_code == CODE_NEWLINE) begin
            cursor_model = cursor_model + COLUMNS;
            cursor_model = cursor_model - cursor_model % COLUMNS;
         end else if (r.char_code == CODE_RETURN) begin
            cursor_model = cursor_model - cursor_model % COLUMNS;
         end else begin
            if (cursor_model < CELLS)
               screen_model[cursor_model] = {attribute_model, r.char_code};
            cursor_model = cursor_model + 1;
         end
         if (cursor_model >= CELLS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
               screen_model[i] = screen_model[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
               screen_model[i] = {attribute_model, CHAR_BLANK};
            cursor_model = CELLS - COLUMNS;
         end
      end else if (r.read_address < CELLS) begin
         o.cell_data = screen_model[r.read_address];
      end
      o.cursor_position = cursor_model[10:0];
      return o;
   endfunction

   function automatic int idle_cycles();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_request(logic kind, logic [7:0] code, logic [10:0] address);
      tccw_req_type r;
      r.kind         = kind;
      r.char_code    = code;
      r.read_address = address;
      outgoing_requests.push_back(r);
      queued_total++;
   endfunction

   function automatic logic [10:0] pick_address();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
      if (pick < 60) return 11'($urandom_range(0, 3 * COLUMNS - 1));
      if (pick < 90) return 11'($urandom_range(0, CELLS - 1));
      return 11'($urandom_range(CELLS, 2047));
   endfunction

   function automatic logic [7:0] printable_code();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CODE_NEWLINE || c == CODE_RETURN);
      return c;
   endfunction

   function automatic void queue_read();
      queue_request(KIND_READ, 8'($urandom_range(0, 255)), pick_address());
   endfunction

   // lines of text with random content, some wrapping, plus stray reads and noise
   function automatic void queue_text(int unsigned count);
      int unsigned goal;
      int unsigned pick;
      int unsigned len;
      goal = queued_total + count;
      while (queued_total < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            queue_read();
         end else if (pick < 30) begin
            queue_request(KIND_PUT, 8'($urandom_range(0, 255)),
                          11'($urandom_range(0, 2047)));
         end else begin
            pick = $urandom_range(0, 99);
            len = (pick < 80) ? $urandom_range(0, 15) :
                  (pick < 97) ? $urandom_range(60, 85) : $urandom_range(150, 170);
            repeat (len) begin
               if ($urandom_range(0, 99) < 15) queue_read();
               queue_request(KIND_PUT, printable_code(), 11'($urandom_range(0, 2047)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
               if (pick < 50)
                  queue_request(KIND_PUT, CODE_RETURN, 11'($urandom_range(0, 2047)));
               queue_request(KIND_PUT, CODE_NEWLINE, 11'($urandom_range(0, 2047)));
            end else begin
               queue_request(KIND_PUT, CODE_RETURN, 11'($urandom_range(0, 2047)));
            end
         end
      end
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (outgoing_requests.size() != 0 || req_valid || predicted_responses.size() != 0);
   endtask

   task automatic write_attribute(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      attribute_model = value;
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_responses.push_back(advance_console(req_payload));
            requests_taken <= requests_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (outgoing_requests.size() > 0) begin
               req_payload <= outgoing_requests.pop_front();
               req_valid   <= 1'b1;
               send_gap = idle_cycles();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
         hold_done  = 1'b1;
         hold_left  = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_cycles();
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      tccw_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_responses.size() == 0) begin
            report_mismatch("response with no request outstanding", 0, 32'(rsp_payload));
         end else begin
            want = predicted_responses.pop_front();
            if (rsp_payload.cursor_position != want.cursor_position)
               report_mismatch("cursor_position", 32'(want.cursor_position),
                               32'(rsp_payload.cursor_position));
            if (rsp_payload.cell_data != want.cell_data)
               report_mismatch("cell_data", 32'(want.cell_data),
                               32'(rsp_payload.cell_data));
         end
      end
   end

   initial begin
      for (int i = 0; i < CELLS; i++) screen_model[i] = {ATTR_RESET, CHAR_BLANK};
      cursor_model    = 0;
      attribute_model = ATTR_RESET;
      queued_total    = 0;
      requests_taken  = 0;
      mismatch_count  = 0;
      no_idle         = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed opening at the reset attribute
      @(negedge clock);
      queue_request(KIND_READ, 8'hFF, 11'd0);
      queue_request(KIND_READ, 8'h00, 11'(CELLS - 1));
      queue_request(KIND_READ, 8'h00, 11'(CELLS));
      queue_request(KIND_READ, 8'hFF, 11'h7FF);
      queue_request(KIND_PUT, 8'h00, 11'h7FF);
      queue_request(KIND_PUT, 8'hFF, 11'd0);
      queue_request(KIND_PUT, 8'h41, 11'h555);
      queue_request(KIND_READ, CODE_NEWLINE, 11'd1);
      queue_request(KIND_PUT, CODE_RETURN, 11'h2AA);
      queue_request(KIND_PUT, 8'h42, 11'd0);
      queue_request(KIND_READ, 8'h00, 11'd0);
      queue_request(KIND_READ, CODE_RETURN, 11'd2);
      queue_request(KIND_PUT, CODE_NEWLINE, 11'd0);
      queue_request(KIND_PUT, CODE_NEWLINE, 11'd0);
      queue_request(KIND_PUT, 8'h7E, 11'd0);
      queue_request(KIND_PUT, CODE_RETURN, 11'd0);
      queue_request(KIND_PUT, CODE_RETURN, 11'd0);
      queue_request(KIND_READ, 8'h00, 11'(2 * COLUMNS));
      queue_request(KIND_READ, 8'h00, 11'(2 * COLUMNS + 1));
      queue_request(KIND_READ, 8'h00, 11'(COLUMNS));

      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            0: write_attribute(8'h00);
            1: write_attribute(8'hFF);
            2: write_attribute(8'($urandom_range(1, 254)));
            3: write_attribute(8'h5A);
            default: write_attribute(8'($urandom_range(0, 255)));
         endcase
         @(negedge clock);
         no_idle = (phase == 3);
         queue_text(LINE_ITEMS);
      end

      wait_idle();
      repeat (TAIL) @(posedge clock);
      if (mismatch_count == 0 && predicted_responses.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
